@@ hdl/pfsc_pkg.sv @@
`default_nettype none

package pfsc_pkg;

  localparam int VALUE_LIMIT  = 65536;
  localparam int COUNT_BITS   = 16;
  localparam int VALUE_BITS   = 16;
  localparam int OUT_BITS     = 16;
  localparam int EPOCH_BITS   = 8;
  localparam int ADDR_BITS    = $clog2(VALUE_LIMIT);
  localparam int ROOT_BITS    = (ADDR_BITS + 1) / 2 + 1;
  localparam int SQ_BITS      = 2 * ROOT_BITS;
  localparam int DIV_CNT_BITS = $clog2(ADDR_BITS);

  localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [EPOCH_BITS-1:0] epoch_t;

  typedef struct packed {
    logic  go;
    addr_t dividend;
    addr_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    addr_t quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ hdl/pfsc_ram.sv @@
`default_nettype none

module pfsc_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/pfsc_div.sv @@
`default_nettype none

module pfsc_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pfsc_pkg::div_req_t req,
  output pfsc_pkg::div_rsp_t      rsp
);

  logic                                 busy_r;
  logic                                 done_r;
  logic [pfsc_pkg::DIV_CNT_BITS-1:0]    cnt_r;
  pfsc_pkg::addr_t                      quo_r;
  pfsc_pkg::addr_t                      rem_r;
  pfsc_pkg::addr_t                      dvs_r;
  logic [pfsc_pkg::ADDR_BITS:0]         shl;
  logic [pfsc_pkg::ADDR_BITS:0]         diff;
  logic                                 fits;

  always_comb begin
    shl  = {rem_r, quo_r[pfsc_pkg::ADDR_BITS-1]};
    diff = shl - {1'b0, dvs_r};
    fits = ~diff[pfsc_pkg::ADDR_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pfsc_pkg::DIV_CNT_BITS'(pfsc_pkg::ADDR_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.go) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[pfsc_pkg::ADDR_BITS-1:0] : shl[pfsc_pkg::ADDR_BITS-1:0];
      quo_r <= {quo_r[pfsc_pkg::ADDR_BITS-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

@@ hdl/prime_factor_share_counter.sv @@
// Channel | Ports                              | Handshake
// input   | in_value[15:0], in_last            | start & !busy
// result  | out_largest_share_count[15:0]      | out_valid, one-cycle strobe
//
// After reset: a clearing pass over all 65536 table entries, then the sieve (a table read
// per multiple visited, and a write if the entry is still empty); busy stays high throughout.
// Per value: 0 and 1 go straight to the finish state; else one lookup and one division
// per prime factor counted with multiplicity (at most 15), by the 16-bit shift-subtract divider.
// Every 256th set ends with a clearing pass over all 65536 count-store entries.
// The receiver cannot stall; a result is shown for one cycle only.
`default_nettype none

module prime_factor_share_counter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_value,
  input  wire logic        in_last,
  output logic             out_valid,
  output logic [15:0]      out_largest_share_count
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_SV_RD_I  = 4'd1;
  localparam logic [3:0] S_SV_CHK_I = 4'd2;
  localparam logic [3:0] S_SV_RD_J  = 4'd3;
  localparam logic [3:0] S_SV_WR_J  = 4'd4;
  localparam logic [3:0] S_IDLE     = 4'd5;
  localparam logic [3:0] S_LOOK     = 4'd6;
  localparam logic [3:0] S_FAC      = 4'd7;
  localparam logic [3:0] S_CNT      = 4'd8;
  localparam logic [3:0] S_DIVW     = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;

  localparam int AB = pfsc_pkg::ADDR_BITS;
  localparam int CB = pfsc_pkg::COUNT_BITS;
  localparam int EB = pfsc_pkg::EPOCH_BITS;
  localparam int RB = pfsc_pkg::ROOT_BITS;
  localparam int QB = pfsc_pkg::SQ_BITS;

  logic [3:0]              state_r, state_nxt;
  pfsc_pkg::addr_t         clr_r, clr_nxt;
  logic                    built_r, built_nxt;
  logic [RB-1:0]           i_r, i_nxt;
  logic [AB:0]             j_r, j_nxt;
  pfsc_pkg::addr_t         x_r, x_nxt;
  pfsc_pkg::addr_t         p_r, p_nxt;
  pfsc_pkg::addr_t         prev_r, prev_nxt;
  logic                    last_r, last_nxt;
  pfsc_pkg::count_t        best_r, best_nxt;
  pfsc_pkg::epoch_t        epoch_r, epoch_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [15:0]             out_cnt_r, out_cnt_nxt;

  logic                    spf_we;
  pfsc_pkg::addr_t         spf_waddr, spf_wdata, spf_raddr, spf_rdata;
  logic                    cnt_we;
  pfsc_pkg::addr_t         cnt_waddr, cnt_raddr;
  logic [EB+CB-1:0]        cnt_wdata, cnt_rdata;

  pfsc_pkg::div_req_t      div_req;
  pfsc_pkg::div_rsp_t      div_rsp;

  logic [RB-1:0]           i_inc;
  logic [QB-1:0]           i_inc_sq, i_sq;
  logic                    sieve_more;
  logic [AB:0]             j_step;
  logic                    j_done;
  pfsc_pkg::addr_t         p_fac;
  pfsc_pkg::count_t        c_old, c_new;
  logic                    in_ok;

  pfsc_ram #(.ADDR_W(AB), .DATA_W(AB)) u_spf_ram (
    .clk   (clk),
    .we    (spf_we),
    .waddr (spf_waddr),
    .wdata (spf_wdata),
    .raddr (spf_raddr),
    .rdata (spf_rdata)
  );

  pfsc_ram #(.ADDR_W(AB), .DATA_W(EB + CB)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  pfsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    i_inc      = i_r + 1'b1;
    i_inc_sq   = QB'(i_inc) * QB'(i_inc);
    i_sq       = QB'(i_r) * QB'(i_r);
    sieve_more = i_inc_sq < QB'(pfsc_pkg::VALUE_LIMIT);
    j_step     = j_r + (AB + 1)'(i_r);
    j_done     = j_step >= (AB + 1)'(pfsc_pkg::VALUE_LIMIT);
    p_fac      = (spf_rdata == '0) ? x_r : spf_rdata;
    c_old      = (cnt_rdata[CB +: EB] == epoch_r) ? cnt_rdata[CB-1:0] : '0;
    c_new      = (c_old == '1) ? c_old : c_old + 1'b1;
    in_ok      = (32'(in_value) < 32'(pfsc_pkg::VALUE_LIMIT)) && (in_value > 16'd1);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    built_nxt     = built_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    x_nxt         = x_r;
    p_nxt         = p_r;
    prev_nxt      = prev_r;
    last_nxt      = last_r;
    best_nxt      = best_r;
    epoch_nxt     = epoch_r;
    out_valid_nxt = 1'b0;
    out_cnt_nxt   = out_cnt_r;

    spf_we    = 1'b0;
    spf_waddr = clr_r;
    spf_wdata = '0;
    spf_raddr = x_r;
    cnt_we    = 1'b0;
    cnt_waddr = clr_r;
    cnt_wdata = '0;
    cnt_raddr = p_fac;

    div_req.go       = 1'b0;
    div_req.dividend = x_r;
    div_req.divisor  = p_fac;

    case (state_r)
      S_CLEAR: begin
        spf_we  = ~built_r;
        cnt_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = built_r ? S_IDLE : S_SV_RD_I;
        end
      end
      S_SV_RD_I: begin
        spf_raddr = AB'(i_r);
        state_nxt = S_SV_CHK_I;
      end
      S_SV_CHK_I: begin
        if (spf_rdata == '0) begin
          j_nxt     = (AB + 1)'(i_sq);
          state_nxt = S_SV_RD_J;
        end else begin
          i_nxt = i_inc;
          if (sieve_more) begin
            state_nxt = S_SV_RD_I;
          end else begin
            built_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SV_RD_J: begin
        spf_raddr = j_r[AB-1:0];
        state_nxt = S_SV_WR_J;
      end
      S_SV_WR_J: begin
        spf_we    = (spf_rdata == '0);
        spf_waddr = j_r[AB-1:0];
        spf_wdata = AB'(i_r);
        j_nxt     = j_step;
        if (!j_done) begin
          state_nxt = S_SV_RD_J;
        end else begin
          i_nxt = i_inc;
          if (sieve_more) begin
            state_nxt = S_SV_RD_I;
          end else begin
            built_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          prev_nxt  = '0;
          last_nxt  = in_last;
          x_nxt     = AB'(in_value);
          state_nxt = in_ok ? S_LOOK : S_FIN;
        end
      end
      S_LOOK: begin
        spf_raddr = x_r;
        state_nxt = S_FAC;
      end
      S_FAC: begin
        p_nxt      = p_fac;
        div_req.go = 1'b1;
        state_nxt  = (p_fac != prev_r) ? S_CNT : S_DIVW;
      end
      S_CNT: begin
        cnt_we    = 1'b1;
        cnt_waddr = p_r;
        cnt_wdata = {epoch_r, c_new};
        prev_nxt  = p_r;
        if (c_new > best_r) begin
          best_nxt = c_new;
        end
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          x_nxt     = div_rsp.quotient;
          state_nxt = (div_rsp.quotient > AB'(1)) ? S_LOOK : S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
        if (last_r) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = (32'(best_r) > 32'(pfsc_pkg::OUT_MAX)) ?
                          pfsc_pkg::OUT_MAX : 16'(best_r);
          best_nxt      = CB'(1);
          epoch_nxt     = epoch_r + 1'b1;
          if (epoch_r == '1) begin
            clr_nxt   = '0;
            state_nxt = S_CLEAR;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      built_r     <= 1'b0;
      i_r         <= RB'(2);
      best_r      <= CB'(1);
      epoch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      built_r     <= built_nxt;
      i_r         <= i_nxt;
      best_r      <= best_nxt;
      epoch_r     <= epoch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r       <= j_nxt;
    x_r       <= x_nxt;
    p_r       <= p_nxt;
    prev_r    <= prev_nxt;
    last_r    <= last_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign busy                    = (state_r != S_IDLE);
  assign out_valid               = out_valid_r;
  assign out_largest_share_count = out_cnt_r;

`ifndef NO_ASSERTIONS
  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_FIN && last_r))
    else $error("result strobe without a finished last item");

  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIVW)
    else $error("divider finished outside the wait state");

  a_best_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    best_r != '0)
    else $error("running maximum dropped to zero");

  a_factor_prime: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CNT |-> p_r > AB'(1))
    else $error("count update for a factor below two");
`endif

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_BEATS = 1080;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int TAIL_CYCLES  = 400;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
    logic        fixed;
    logic [15:0] want;
  } stim_row_t;

  localparam int DIR_ROWS = 22;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{16'd0,     1'b1, 1'b1, 16'd1},
    '{16'd1,     1'b1, 1'b1, 16'd1},
    '{16'd65535, 1'b1, 1'b1, 16'd1},
    '{16'd2,     1'b0, 1'b0, 16'd0},
    '{16'd4,     1'b0, 1'b0, 16'd0},
    '{16'd8,     1'b1, 1'b1, 16'd3},
    '{16'd32768, 1'b0, 1'b0, 16'd0},
    '{16'd65534, 1'b1, 1'b1, 16'd2},
    '{16'd65521, 1'b0, 1'b0, 16'd0},
    '{16'd65521, 1'b1, 1'b1, 16'd2},
    '{16'd0,     1'b0, 1'b0, 16'd0},
    '{16'd1,     1'b0, 1'b0, 16'd0},
    '{16'd65535, 1'b0, 1'b0, 16'd0},
    '{16'd30030, 1'b1, 1'b0, 16'd0},
    '{16'd12,    1'b0, 1'b0, 16'd0},
    '{16'd18,    1'b0, 1'b0, 16'd0},
    '{16'd27,    1'b0, 1'b0, 16'd0},
    '{16'd9,     1'b1, 1'b0, 16'd0},
    '{16'd6,     1'b0, 1'b0, 16'd0},
    '{16'd10,    1'b0, 1'b0, 16'd0},
    '{16'd15,    1'b1, 1'b0, 16'd0},
    '{16'd49152, 1'b1, 1'b1, 16'd1}
  };

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_value;
  logic        in_last;
  logic        out_valid;
  logic [15:0] out_largest_share_count;

  logic        beat_fixed;
  logic [15:0] beat_want;
  logic        idle_on;

  pfsc_pkg::addr_t  spf_table [pfsc_pkg::VALUE_LIMIT];
  pfsc_pkg::count_t prime_tally [pfsc_pkg::VALUE_LIMIT];
  pfsc_pkg::count_t best_share;
  pfsc_pkg::addr_t  touched_primes [$];
  logic [15:0]      share_expect_q [$];

  int          cycle_count;
  int          miss_count;

  prime_factor_share_counter dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_value                (in_value),
    .in_last                 (in_last),
    .out_valid               (out_valid),
    .out_largest_share_count (out_largest_share_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void build_spf_table();
    int i;
    int j;
    spf_table[0] = '0;
    spf_table[1] = '0;
    for (i = 2; i < pfsc_pkg::VALUE_LIMIT; i++) spf_table[i] = pfsc_pkg::addr_t'(i);
    for (i = 2; i * i < pfsc_pkg::VALUE_LIMIT; i++) begin
      if (spf_table[i] == pfsc_pkg::addr_t'(i)) begin
        for (j = i * i; j < pfsc_pkg::VALUE_LIMIT; j += i) begin
          if (spf_table[j] == pfsc_pkg::addr_t'(j)) spf_table[j] = pfsc_pkg::addr_t'(i);
        end
      end
    end
    for (i = 0; i < pfsc_pkg::VALUE_LIMIT; i++) prime_tally[i] = '0;
    best_share = pfsc_pkg::count_t'(1);
  endfunction

  // Factor one value into the share tallies; return 1 with the set's best on last.
  function automatic bit tally_factors(input logic [15:0] v, input logic l,
                                       output logic [15:0] best);
    int               x;
    pfsc_pkg::addr_t  p;
    pfsc_pkg::addr_t  prev;
    pfsc_pkg::count_t c;
    x    = v;
    prev = '0;
    best = '0;
    while (x > 1) begin
      p = spf_table[x];
      if (p < 2) break;
      if (p != prev) begin
        c = prime_tally[p];
        if (c == '0) touched_primes = {touched_primes, p};
        if (c != '1) c = c + 1'b1;
        prime_tally[p] = c;
        if (c > best_share) best_share = c;
        prev = p;
      end
      x = x / p;
    end
    if (!l) return 1'b0;
    best = (best_share > pfsc_pkg::count_t'(pfsc_pkg::OUT_MAX)) ?
           pfsc_pkg::OUT_MAX : best_share[15:0];
    while (touched_primes.size() != 0) prime_tally[touched_primes.pop_front()] = '0;
    best_share = pfsc_pkg::count_t'(1);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    logic [15:0] predicted;
    logic [15:0] want;
    if (rst_n === 1'b1) begin
      if (start === 1'b1 && busy === 1'b0) begin
        if (tally_factors(in_value, in_last, predicted))
          share_expect_q = {share_expect_q, beat_fixed ? beat_want : predicted};
      end
      if (out_valid === 1'b1) begin
        if (share_expect_q.size() == 0) begin
          if (miss_count < 10)
            $display("unexpected result %0d at cycle %0d", out_largest_share_count,
                     cycle_count);
          miss_count++;
        end else begin
          want = share_expect_q.pop_front();
          if (out_largest_share_count !== want) begin
            if (miss_count < 10)
              $display("largest_share_count: expected %0d, got %0d at cycle %0d", want,
                       out_largest_share_count, cycle_count);
            miss_count++;
          end
        end
      end
    end
  end

  task automatic send_beat(input logic [15:0] v, input logic l, input logic fx,
                           input logic [15:0] w);
    int gap;
    if (idle_on && $urandom_range(99) < 9) begin
      gap = $urandom_range(4, 1);
      @(negedge clk);
      start <= 1'b0;
      while (busy !== 1'b0) @(negedge clk);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start      <= 1'b1;
    in_value   <= v;
    in_last    <= l;
    beat_fixed <= fx;
    beat_want  <= w;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (share_expect_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int          i;
    int          beats;
    int          set_len;
    int          k;
    int          shared_p;
    logic [15:0] v;
    bit          drained;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_value   = '0;
    in_last    = 1'b0;
    beat_fixed = 1'b0;
    beat_want  = '0;
    idle_on    = 1'b1;
    miss_count = 0;
    build_spf_table();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++)
      send_beat(dir_rows[i].value, dir_rows[i].last, dir_rows[i].fixed, dir_rows[i].want);
    drain_results();

    beats   = 0;
    drained = 1'b0;
    while (beats < RANDOM_BEATS) begin
      idle_on  = !(beats >= 300 && beats < 700);
      set_len  = ($urandom_range(99) < 5) ? $urandom_range(60, 20) : $urandom_range(6, 1);
      shared_p = $urandom_range(1) ? spf_table[$urandom_range(300, 2)]
                                   : spf_table[$urandom_range(65535, 2)];
      for (k = 0; k < set_len; k++) begin
        case ($urandom_range(9))
          0, 1, 2: v = 16'($urandom_range(65535));
          3, 4, 5: v = 16'(shared_p * $urandom_range(65535 / shared_p, 1));
          6:       v = 16'($urandom_range(1));
          7:       v = 16'(1 << $urandom_range(15));
          8:       v = 16'($urandom_range(1000, 2));
          default: v = 16'hFFFF ^ 16'($urandom_range(255));
        endcase
        send_beat(v, k == set_len - 1, 1'b0, '0);
        beats++;
      end
      if (!drained && beats >= 550) begin
        drain_results();
        drained = 1'b1;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (miss_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             share_expect_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/pfsc_pkg.sv
hdl/pfsc_ram.sv
hdl/pfsc_div.sv
hdl/prime_factor_share_counter.sv
tb/tb.sv
